// File: sv/inverse_distance_blend_nearest3_top_macros.svh
// Assertion macros shared by the inverse-distance blend RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef INVERSE_DISTANCE_BLEND_NEAREST3_TOP_MACROS_SVH
`define INVERSE_DISTANCE_BLEND_NEAREST3_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define IDBN3_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define IDBN3_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define IDBN3_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define IDBN3_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: sv/idbn3_pkg.sv
// Shared types and constants for the inverse-distance blend block.
// Used by the controller, datapath, arithmetic units and top level.
package idbn3_pkg;
  localparam int MAX_POINTS    = 16;
  localparam int NEAREST_COUNT = 3;
  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int NP_W   = $clog2(MAX_POINTS + 1);
  localparam int RANK_W = 2;
  localparam int D2_W   = 33;
  localparam int ROOT_W = 17;
  localparam int INV_W  = 33;
  localparam int TOT_W  = 35;
  localparam int WGT_W  = 17;
  localparam int CNT_W  = 6;
  localparam logic [WGT_W-1:0] WEIGHT_ONE = 17'h10000;
  localparam logic REG_NUM_POINTS = 1'b0;
  localparam logic REG_THRESHOLD  = 1'b1;
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam logic DIV_INV    = 1'b0;
  localparam logic DIV_WEIGHT = 1'b1;

  typedef struct packed {
    logic              load;
    logic              capture;
    logic              diff;
    logic              sq;
    logic              sum;
    logic              ins;
    logic              sqrt_start;
    logic              div_start;
    logic              div_mode;
    logic              inv_store;
    logic              out_load;
    logic              out_hit;
    logic              out_last;
    logic [IDX_W-1:0]  idx;
    logic [RANK_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic            hit;
    logic            sqrt_done;
    logic            div_done;
    logic [NP_W-1:0] n_pts;
  } sts_t;
endpackage

// File: sv/idbn3_sqrt.sv
// Iterative floor square root, one result bit settled per step.
// Depends on idbn3_pkg for widths.
module idbn3_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [idbn3_pkg::D2_W-1:0]    value,
  output logic [idbn3_pkg::ROOT_W-1:0]  root,
  output logic                          done
);
  import idbn3_pkg::*;
  localparam int W = 2 * ROOT_W;

  logic [W-1:0] num_r, num_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic         busy_r, busy_nxt, done_r, done_nxt;
  logic [W-1:0] trial;

  assign trial = res_r + bit_r;

  always_comb begin
    num_nxt  = num_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = W'(value);
      res_nxt  = '0;
      bit_nxt  = W'(1) << (W - 2);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (num_r >= trial) begin
        num_nxt = num_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign root = res_r[ROOT_W-1:0];
  assign done = done_r;
endmodule

// File: sv/idbn3_div.sv
// Restoring divider, one quotient bit per cycle, with a preloaded partial
// remainder so short quotients take fewer steps. Depends on idbn3_pkg.
module idbn3_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [idbn3_pkg::TOT_W-1:0]  rem_init,
  input  logic [idbn3_pkg::INV_W-1:0]  bits,
  input  logic [idbn3_pkg::CNT_W-1:0]  nbits,
  input  logic [idbn3_pkg::TOT_W-1:0]  divisor,
  output logic [idbn3_pkg::INV_W-1:0]  quotient,
  output logic                         done
);
  import idbn3_pkg::*;

  logic [TOT_W-1:0] rem_r, rem_nxt, div_r, div_nxt;
  logic [INV_W-1:0] sh_r, sh_nxt, q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [TOT_W:0]   trial;

  assign trial = {rem_r, sh_r[INV_W-1]};

  always_comb begin
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = rem_init;
      div_nxt  = divisor;
      sh_nxt   = bits;
      q_nxt    = '0;
      cnt_nxt  = nbits;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so the difference fits.
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = TOT_W'(trial - {1'b0, div_r});
        q_nxt   = {q_r[INV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[TOT_W-1:0];
        q_nxt   = {q_r[INV_W-2:0], 1'b0};
      end
      sh_nxt  = {sh_r[INV_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient = q_r;
  assign done     = done_r;
endmodule

// File: sv/idbn3_datapath.sv
// Datapath: point table, distance pipeline, nearest-three list, weights and
// output register. Depends on idbn3_pkg, idbn3_sqrt and idbn3_div.
module idbn3_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [7:0]                     cfg_wdata,
  input  logic [idbn3_pkg::IDX_W-1:0]    point_index,
  input  logic signed [15:0]             point_x,
  input  logic signed [15:0]             point_y,
  input  logic [7:0]                     point_state,
  input  logic signed [15:0]             query_x,
  input  logic signed [15:0]             query_y,
  input  idbn3_pkg::cmd_t                cmd,
  output idbn3_pkg::sts_t                sts,
  output logic [7:0]                     out_state,
  output logic [idbn3_pkg::WGT_W-1:0]    out_weight,
  output logic [idbn3_pkg::RANK_W-1:0]   out_rank,
  output logic                           out_last
);
  import idbn3_pkg::*;
  localparam int NC = NEAREST_COUNT;

  logic [NP_W-1:0]  num_points_r;
  logic [7:0]       threshold_r;

  logic signed [15:0] px_mem [MAX_POINTS];
  logic signed [15:0] py_mem [MAX_POINTS];
  logic [7:0]         ps_mem [MAX_POINTS];

  logic signed [15:0] qx_r, qy_r;
  logic [15:0]        dx_r, dy_r;
  logic [31:0]        sqx_r, sqy_r;
  logic [D2_W-1:0]    d2_r;
  logic [7:0]         st_r;

  logic [D2_W-1:0]    best_d_r  [NC];
  logic [7:0]         best_st_r [NC];
  logic [NC-1:0]      best_v_r;
  logic [INV_W-1:0]   inv_r     [NC];
  logic [TOT_W-1:0]   total_r;

  logic signed [16:0] diff_x, diff_y;
  logic [16:0]        abs_x, abs_y;
  logic [NC-1:0]      le;
  logic [RANK_W-1:0]  pos;

  logic [ROOT_W-1:0]  root;
  logic               sqrt_done, div_done;
  logic [INV_W-1:0]   quotient;
  logic [TOT_W-1:0]   rem_init, divisor;
  logic [INV_W-1:0]   div_bits;
  logic [CNT_W-1:0]   nbits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= '0;
      threshold_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_NUM_POINTS) num_points_r <= cfg_wdata[NP_W-1:0];
      if (cfg_index == REG_THRESHOLD)  threshold_r  <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_mem[point_index] <= point_x;
      py_mem[point_index] <= point_y;
      ps_mem[point_index] <= point_state;
    end
  end

  assign diff_x = 17'(qx_r) - 17'(px_mem[cmd.idx]);
  assign diff_y = 17'(qy_r) - 17'(py_mem[cmd.idx]);
  assign abs_x  = diff_x[16] ? 17'(-diff_x) : 17'(diff_x);
  assign abs_y  = diff_y[16] ? 17'(-diff_y) : 17'(diff_y);

  // The new point goes behind every kept point of equal distance, so an
  // earlier slot wins a tie.
  always_comb begin
    for (int j = 0; j < NC; j++) begin
      le[j] = best_v_r[j] && (best_d_r[j] <= d2_r);
    end
    pos = RANK_W'($countones(le));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qx_r     <= query_x;
      qy_r     <= query_y;
      best_v_r <= '0;
      total_r  <= '0;
    end
    if (cmd.diff) begin
      dx_r <= abs_x[15:0];
      dy_r <= abs_y[15:0];
      st_r <= ps_mem[cmd.idx];
    end
    if (cmd.sq) begin
      sqx_r <= dx_r * dx_r;
      sqy_r <= dy_r * dy_r;
    end
    if (cmd.sum) d2_r <= D2_W'(sqx_r) + D2_W'(sqy_r);
    if (cmd.ins && (int'(pos) < NC)) begin
      for (int j = 0; j < NC; j++) begin
        if (j == int'(pos)) begin
          best_d_r[j]  <= d2_r;
          best_st_r[j] <= st_r;
          best_v_r[j]  <= 1'b1;
        end else if (j > int'(pos)) begin
          best_d_r[j]  <= best_d_r[j-1];
          best_st_r[j] <= best_st_r[j-1];
          best_v_r[j]  <= best_v_r[j-1];
        end
      end
    end
    if (cmd.inv_store) begin
      inv_r[cmd.k] <= quotient;
      total_r      <= total_r + TOT_W'(quotient);
    end
    if (cmd.out_load) begin
      if (cmd.out_hit) begin
        out_state  <= st_r;
        out_weight <= WEIGHT_ONE;
        out_rank   <= '0;
      end else begin
        out_state  <= best_st_r[cmd.k];
        out_weight <= quotient[WGT_W-1:0];
        out_rank   <= cmd.k;
      end
      out_last <= cmd.out_last;
    end
  end

  // A weight never exceeds 1.0, so its quotient has at most 17 bits and the
  // division starts from the dividend shifted down by that many places.
  always_comb begin
    if (cmd.div_mode == DIV_WEIGHT) begin
      rem_init = TOT_W'(inv_r[cmd.k][INV_W-1:1]);
      div_bits = {inv_r[cmd.k][0], {(INV_W-1){1'b0}}};
      nbits    = CNT_W'(WGT_W);
      divisor  = total_r;
    end else begin
      rem_init = '0;
      div_bits = {1'b1, {(INV_W-1){1'b0}}};
      nbits    = CNT_W'(INV_W);
      divisor  = TOT_W'(root);
    end
  end

  idbn3_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .value (best_d_r[cmd.k]),
    .root  (root),
    .done  (sqrt_done)
  );

  idbn3_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .rem_init (rem_init),
    .bits     (div_bits),
    .nbits    (nbits),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  assign sts.hit       = (d2_r <= D2_W'(threshold_r));
  assign sts.sqrt_done = sqrt_done;
  assign sts.div_done  = div_done;
  assign sts.n_pts     = (num_points_r > NP_W'(MAX_POINTS)) ? NP_W'(MAX_POINTS)
                                                            : num_points_r;
endmodule

// File: sv/idbn3_ctrl.sv
// Controller: sequences loads, the distance scan, roots, inverses and
// weights, and owns the output valid. Depends on idbn3_pkg and the macros.
`include "inverse_distance_blend_nearest3_top_macros.svh"
module idbn3_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_kind,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  idbn3_pkg::sts_t     sts,
  output idbn3_pkg::cmd_t     cmd
);
  import idbn3_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQ, S_SUM, S_INS, S_ROOT_GO, S_ROOT_WAIT,
    S_INV_GO, S_INV_WAIT, S_W_GO, S_W_WAIT, S_PUT, S_HIT_PUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [RANK_W-1:0] k_r, k_nxt, count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free, k_last;

  assign out_free = !out_valid_r || out_tready;
  assign k_last   = (k_r == count_r - RANK_W'(1));

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    count_nxt = count_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    cmd.k     = k_r;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            idx_nxt     = '0;
            if (sts.n_pts != '0) state_nxt = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_INS;
      end
      S_INS: begin
        cmd.ins = 1'b1;
        if (sts.hit) begin
          state_nxt = S_HIT_PUT;
        end else if (NP_W'(idx_r) == sts.n_pts - NP_W'(1)) begin
          count_nxt = (sts.n_pts < NP_W'(NEAREST_COUNT)) ? RANK_W'(sts.n_pts)
                                                         : RANK_W'(NEAREST_COUNT);
          k_nxt     = '0;
          state_nxt = S_ROOT_GO;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_DIFF;
        end
      end
      S_ROOT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (sts.sqrt_done) state_nxt = S_INV_GO;
      end
      S_INV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_mode  = DIV_INV;
        state_nxt     = S_INV_WAIT;
      end
      S_INV_WAIT: begin
        if (sts.div_done) begin
          cmd.inv_store = 1'b1;
          if (k_last) begin
            k_nxt     = '0;
            state_nxt = S_W_GO;
          end else begin
            k_nxt     = k_r + RANK_W'(1);
            state_nxt = S_ROOT_GO;
          end
        end
      end
      S_W_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_mode  = DIV_WEIGHT;
        state_nxt     = S_W_WAIT;
      end
      S_W_WAIT: begin
        cmd.div_mode = DIV_WEIGHT;
        if (sts.div_done) state_nxt = S_PUT;
      end
      S_PUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = k_last;
          if (k_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + RANK_W'(1);
            state_nxt = S_W_GO;
          end
        end
      end
      S_HIT_PUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_hit  = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      k_r         <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `IDBN3_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.out_load && out_valid_r, out_tready, "output beat overwritten before it was taken")
  `IDBN3_ASSERT_NEXT(a_div_busy, clk, rst_n, cmd.div_start, !sts.div_done, "divider finished in the cycle after start")
  `IDBN3_ASSERT_IMPL(a_rank_range, clk, rst_n, state_r == S_ROOT_GO || state_r == S_W_GO || state_r == S_PUT, k_r < count_r, "rank index beyond the selected count")
endmodule

// File: sv/inverse_distance_blend_nearest3_top.sv
// Inverse-distance blend over the three nearest points of a 16-entry table.
// A load beat writes the table from idle. A query walks the enabled points
// through the distance pipeline (difference, square, sum, insert; one multiplier
// pair), then for each of up to three selected points runs the shared square
// root (17 steps) and the shared divider (33 steps for the inverse, 17 for the
// weight), one bit per cycle. A point whose squared distance is within the
// threshold ends the scan early and gives one beat of weight 1.0. Results leave
// through an output register; the next beat is accepted once the controller is
// idle again. Depends on idbn3_pkg, idbn3_ctrl and idbn3_datapath.
module inverse_distance_blend_nearest3_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // point_index[3:0], point_x[19:4], point_y[35:20], point_state[43:36],
  // query_x[59:44], query_y[75:60], zero pad above
  input  logic [79:0] in_tdata,
  // kind[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // state_id[7:0], weight[24:8], rank[26:25], zero pad above
  output logic [31:0] out_tdata,
  output logic        out_tlast
);
  import idbn3_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [7:0]        out_state;
  logic [WGT_W-1:0]  out_weight;
  logic [RANK_W-1:0] out_rank;

  idbn3_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  idbn3_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .point_index (in_tdata[3:0]),
    .point_x     (in_tdata[19:4]),
    .point_y     (in_tdata[35:20]),
    .point_state (in_tdata[43:36]),
    .query_x     (in_tdata[59:44]),
    .query_y     (in_tdata[75:60]),
    .cmd         (cmd),
    .sts         (sts),
    .out_state   (out_state),
    .out_weight  (out_weight),
    .out_rank    (out_rank),
    .out_last    (out_tlast)
  );

  assign out_tdata = {5'b0, out_rank, out_weight, out_state};
endmodule

// File: tb/inverse_distance_blend_nearest3_top_tb.sv
// Testbench for the inverse-distance blend over the three nearest table points.
// Drives load and query beats with random gaps and checks every result beat
// against a predictor kept in this file. Depends on idbn3_pkg and the top level.
`timescale 1ns / 100ps

module inverse_distance_blend_nearest3_top_tb;
  import idbn3_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [3:0] pidx;
    logic [15:0] px;
    logic [15:0] py;
    logic [7:0] pst;
    logic [15:0] qx;
    logic [15:0] qy;
  } blend_req_t;

  typedef struct packed {
    logic [7:0]  state_id;
    logic [16:0] weight;
    logic [1:0]  rank;
    logic        last;
  } blend_res_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic cfg_index = REG_NUM_POINTS;
  logic [7:0] cfg_wdata = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [79:0] in_tdata = 0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [31:0] out_tdata;
  logic out_tlast;

  always #6 clk = ~clk;

  inverse_distance_blend_nearest3_top DUT (.*);

  blend_req_t pending_beats[$];
  blend_res_t expected_beats[$];
  logic [15:0] tab_x[MAX_POINTS];
  logic [15:0] tab_y[MAX_POINTS];
  logic [7:0]  tab_st[MAX_POINTS];
  int unsigned active_pts;
  int unsigned thresh;
  int errors = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  // Handshakes seen at the rising edge, acted on at the following falling edge.
  bit in_acc = 0;
  bit out_acc = 0;

  task automatic queue_beat(blend_req_t r);
    pending_beats.insert(pending_beats.size(), r);
  endtask

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Updates the table or appends the blend results of one query.
  task automatic predict_blend(blend_req_t r);
    longint unsigned d2[MAX_POINTS];
    bit taken[MAX_POINTS];
    int sel[3];
    longint unsigned inv[3];
    longint unsigned total, dx, dy;
    int cnt, best;
    blend_res_t e;
    if (r.kind == KIND_LOAD) begin
      tab_x[r.pidx] = r.px;
      tab_y[r.pidx] = r.py;
      tab_st[r.pidx] = r.pst;
      return;
    end
    if (active_pts == 0) return;
    for (int i = 0; i < active_pts; i++) begin
      dx = longint'($signed(r.qx)) - longint'($signed(tab_x[i]));
      dy = longint'($signed(r.qy)) - longint'($signed(tab_y[i]));
      if ($signed(dx) < 0) dx = -dx;
      if ($signed(dy) < 0) dy = -dy;
      d2[i] = dx * dx + dy * dy;
      if (d2[i] <= thresh) begin
        e = '{tab_st[i], WEIGHT_ONE, 2'd0, 1'b1};
        expected_beats.insert(expected_beats.size(), e);
        return;
      end
      taken[i] = 0;
    end
    cnt = active_pts < 3 ? active_pts : 3;
    total = 0;
    for (int k = 0; k < cnt; k++) begin
      best = -1;
      for (int i = 0; i < active_pts; i++)
        if (!taken[i] && (best < 0 || d2[i] < d2[best])) best = i;
      taken[best] = 1;
      sel[k] = best;
      inv[k] = (64'd1 << 32) / root_floor(d2[best]);
      total += inv[k];
    end
    for (int k = 0; k < cnt; k++) begin
      e.state_id = tab_st[sel[k]];
      e.weight = 17'((inv[k] << 16) / total);
      e.rank = 2'(k);
      e.last = (k == cnt - 1);
      expected_beats.insert(expected_beats.size(), e);
    end
  endtask

  // Driver: one beat at a time with a random gap before each.
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_acc) begin
        in_tvalid <= 0;
        in_gap = $urandom_range(0, 6);
      end else if (!in_tvalid) begin
        if (in_gap > 0) in_gap--;
        else if (pending_beats.size() > 0) begin
          blend_req_t r;
          r = pending_beats.pop_front();
          predict_blend(r);
          in_tdata <= {4'b0, r.qy, r.qx, r.pst, r.py, r.px, r.pidx};
          in_tuser <= r.kind;
          in_tvalid <= 1;
        end
      end
    end
  end

  // Receiver stalls are drawn per result beat.
  int out_gap = 0;
  always @(negedge clk) begin
    if (out_acc) out_gap = $urandom_range(0, 6);
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  always @(posedge clk) begin
    in_acc <= rst_n && in_tvalid && in_tready;
    out_acc <= rst_n && out_tvalid && out_tready;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        blend_res_t got, e;
        got = {out_tdata[7:0], out_tdata[24:8], out_tdata[26:25], out_tlast};
        if (expected_beats.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %h", got);
        end else begin
          e = expected_beats.pop_front();
          if (got !== e) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp st=%0d w=%0d r=%0d l=%0d got st=%0d w=%0d r=%0d l=%0d",
                       e.state_id, e.weight, e.rank, e.last,
                       got.state_id, got.weight, got.rank, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= 8'(val);
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_NUM_POINTS) active_pts = val > MAX_POINTS ? MAX_POINTS : val;
    else thresh = val;
  endtask

  task automatic wait_drained();
    while (pending_beats.size() > 0 || in_tvalid || expected_beats.size() > 0)
      @(posedge clk);
    // A load or an empty query may still be in flight.
    repeat (400) @(posedge clk);
  endtask

  function automatic blend_req_t load_beat(int idx, int x, int y, int st);
    blend_req_t r;
    r = '{KIND_LOAD, 4'(idx), 16'(x), 16'(y), 8'(st), 16'($urandom), 16'($urandom)};
    return r;
  endfunction

  function automatic blend_req_t query_beat(int x, int y);
    blend_req_t r;
    r = '{KIND_QUERY, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
          16'(x), 16'(y)};
    return r;
  endfunction

  function automatic int near_coord(int base);
    return $urandom_range(0, 3) == 0 ? int'($urandom) : base + int'($urandom_range(0, 64)) - 32;
  endfunction

  initial begin
    int np, th;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // Empty table: queries give nothing.
    queue_beat(query_beat(0, 0));
    for (int i = 0; i < MAX_POINTS; i++)
      queue_beat(load_beat(i, (i * 4099) ^ 16'h8000, i * 300 - 2000, i));
    queue_beat(load_beat(15, 16'h7fff, 16'h8000, 255));
    wait_drained();
    write_reg(REG_NUM_POINTS, 1);
    write_reg(REG_THRESHOLD, 0);
    queue_beat(query_beat(16'h7fff, 16'h7fff));
    wait_drained();
    write_reg(REG_NUM_POINTS, 2);
    queue_beat(query_beat(16'h8000, 16'h8000));
    wait_drained();
    // Saturating count, tied distances, exact hit and large threshold.
    write_reg(REG_NUM_POINTS, 31);
    write_reg(REG_THRESHOLD, 255);
    queue_beat(load_beat(3, 100, 0, 33));
    queue_beat(load_beat(4, -100, 0, 44));
    queue_beat(load_beat(5, 0, 100, 55));
    queue_beat(query_beat(0, 0));
    queue_beat(query_beat(100, 5));
    queue_beat(query_beat(16'h7fff, 16'h8000));
    queue_beat(query_beat(16'h8000, 16'h7fff));
    wait_drained();
    write_reg(REG_NUM_POINTS, 16);
    write_reg(REG_THRESHOLD, 0);
    queue_beat(query_beat(100, 0));
    queue_beat(query_beat(0, 0));
    wait_drained();
    // Random phases: mostly queries near the loaded points.
    for (int ph = 0; ph < 12; ph++) begin
      np = (ph % 4 == 0) ? $urandom_range(0, 3) : $urandom_range(1, 20);
      th = (ph % 3 == 0) ? 255 : $urandom_range(0, 255);
      write_reg(REG_NUM_POINTS, np);
      write_reg(REG_THRESHOLD, th);
      for (int j = 0; j < 28; j++) begin
        if ($urandom_range(0, 4) == 0)
          queue_beat(load_beat($urandom_range(0, 15),
                               int'($urandom), int'($urandom), int'($urandom)));
        else begin
          int s;
          s = $urandom_range(0, 15);
          queue_beat(query_beat(near_coord(int'($signed(tab_x[s]))),
                                near_coord(int'($signed(tab_y[s])))));
        end
      end
      wait_drained();
    end
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+sv
sv/idbn3_pkg.sv
sv/idbn3_sqrt.sv
sv/idbn3_div.sv
sv/idbn3_datapath.sv
sv/idbn3_ctrl.sv
sv/inverse_distance_blend_nearest3_top.sv
tb/inverse_distance_blend_nearest3_top_tb.sv
